FILE: rtl/core/hssp_pkg.sv
// ----------------------------------------------------------------------------
// hssp_pkg
// Types, constants and the half-step coil pattern for the stepper positioner.
// ----------------------------------------------------------------------------
package hssp_pkg;

   localparam int POS_W       = 16;
   localparam int INTERVAL_W  = 20;
   localparam int PHASE_W     = 3;
   localparam int COIL_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 24;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_LOAD = 1'b1
   } kind_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_LIMIT    = 2'd1;

   localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RESET = 20'd14648;
   localparam logic [POS_W-1:0]      WRAP_LIMIT_RESET    = 16'd4080;
   localparam logic [INTERVAL_W-1:0] ELAPSED_MAX         = '1;

   typedef struct packed {
      kind_type         kind;
      logic [POS_W-1:0] target_position;
      logic [POS_W-1:0] new_position;
   } item_type;

   typedef struct packed {
      logic [COIL_W-1:0] coils;
      logic              stepped;
      logic              ready_res;
      logic [POS_W-1:0]  position;
   } result_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] step_interval;
      logic [POS_W-1:0]      wrap_limit;
   } cfg_type;

   function automatic logic [COIL_W-1:0] phase_coils(input logic [PHASE_W-1:0] ph);
      logic [COIL_W-1:0] c;
      case (ph)
         3'd0:    c = 4'h1;
         3'd1:    c = 4'h3;
         3'd2:    c = 4'h2;
         3'd3:    c = 4'h6;
         3'd4:    c = 4'h4;
         3'd5:    c = 4'hC;
         3'd6:    c = 4'h8;
         3'd7:    c = 4'h9;
         default: c = 4'h0;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/core/hssp_ingress.sv
// ----------------------------------------------------------------------------
// hssp_ingress
// Input register: holds one request until the step logic takes it.
// ----------------------------------------------------------------------------
module hssp_ingress
   import hssp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  item_type req_item,
   input  logic     fire,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_tready = !valid_ff || fire;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/core/hssp_motion.sv
// ----------------------------------------------------------------------------
// hssp_motion
// Control registers, motor state and the single-pass half-step decision.
// ----------------------------------------------------------------------------
module hssp_motion
   import hssp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   fire,
   input  item_type               item,
   output result_type             result
);

   cfg_type               cfg_ff, cfg_in;
   logic [POS_W-1:0]      position_ff, position_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [INTERVAL_W-1:0] elapsed_ff, elapsed_in;
   logic [COIL_W-1:0]     coil_ff, coil_in;

   logic [INTERVAL_W-1:0] elapsed_inc;
   logic [PHASE_W-1:0]    phase_next;
   logic [POS_W:0]        pos_inc;
   logic [POS_W-1:0]      pos_step;
   logic                  do_step;
   logic                  arrive;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STEP_INTERVAL: cfg_in.step_interval = csr_data;
            CSR_WRAP_LIMIT:    cfg_in.wrap_limit    = csr_data[POS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      phase_next  = phase_ff + 1'b1;
      pos_inc     = {1'b0, position_ff} + 1'b1;
      // past the wrap limit or the 16-bit range goes back to zero
      pos_step    = (pos_inc > {1'b0, cfg_ff.wrap_limit}) ? '0 : pos_inc[POS_W-1:0];
      do_step     = (item.kind == KIND_TICK) && (position_ff != item.target_position)
                    && (elapsed_inc >= cfg_ff.step_interval);
      arrive      = do_step && (pos_step == item.target_position);

      position_in = position_ff;
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      coil_in     = coil_ff;
      if (item.kind == KIND_LOAD) begin
         position_in = item.new_position;
      end else if (do_step) begin
         position_in = pos_step;
         phase_in    = phase_next;
         elapsed_in  = '0;
         coil_in     = arrive ? '0 : phase_coils(phase_next);
      end else begin
         elapsed_in = elapsed_inc;
      end

      result.coils     = coil_in;
      result.stepped   = do_step;
      result.ready_res = arrive;
      result.position  = position_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_interval <= STEP_INTERVAL_RESET;
         cfg_ff.wrap_limit    <= WRAP_LIMIT_RESET;
         position_ff          <= '0;
         phase_ff             <= '0;
         elapsed_ff           <= ELAPSED_MAX;
         coil_ff              <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (fire) begin
            position_ff <= position_in;
            phase_ff    <= phase_in;
            elapsed_ff  <= elapsed_in;
            coil_ff     <= coil_in;
         end
      end
   end

endmodule

FILE: rtl/core/hssp_egress.sv
// ----------------------------------------------------------------------------
// hssp_egress
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hssp_egress
   import hssp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  result_type            result,
   output logic                  take_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign take_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (take_ready) begin
         valid_in  = fire;
         result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, result_ff.position, result_ff.ready_res,
                        result_ff.stepped, result_ff.coils};

endmodule

FILE: rtl/core/half_step_stepper_positioner.sv
// ----------------------------------------------------------------------------
// half_step_stepper_positioner
// Half-step four-coil stepper sequencer that steps toward a target position.
//
//   channel | direction | tdata / data                     | tuser
//   req_    | in        | target_position, new_position    | kind
//   rsp_    | out       | coils, stepped, ready_res, pos   | -
//   csr_    | in        | index 0 step_interval, 1 wrap    | -
//
// one request per cycle while results are taken; each result passes the input register, then the result register
// the loop through position, phase and elapsed closes through combinational logic
// reset clears position, phase and coils, saturates the elapsed count and loads the default control values
// a stalled result holds the input register, so req_tready drops with it
// ----------------------------------------------------------------------------
module half_step_stepper_positioner
   import hssp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // target_position, new_position
   input  logic                   req_tuser,  // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // coils, stepped, ready_res, position, pad
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       take_ready;
   logic       fire;
   result_type result;

   assign csr_ready = 1'b1;

   assign req_item.kind            = kind_type'(req_tuser);
   assign req_item.target_position = req_tdata[POS_W-1:0];
   assign req_item.new_position    = req_tdata[2*POS_W-1:POS_W];

   assign fire = item_valid && take_ready;

   hssp_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .fire       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   hssp_motion u_motion (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .fire      (fire),
      .item      (item),
      .result    (result)
   );

   hssp_egress u_egress (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .take_ready (take_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/core/hssp_checker.sv
// ----------------------------------------------------------------------------
// hssp_checker
// Port-level checks on the stepper positioner, bound to the top level.
// ----------------------------------------------------------------------------
module hssp_checker
   import hssp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // stalled result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // arrival only on a step, and it releases the coils
   a_ready_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> rsp_tdata[4] && (rsp_tdata[3:0] == 4'h0))
      else $error("ready_res without step or with coils driven");

   // a step that does not arrive drives one or two adjacent coils
   a_step_coils: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] && !rsp_tdata[5] |->
         ($countones(rsp_tdata[3:0]) == 1) || ($countones(rsp_tdata[3:0]) == 2))
      else $error("step with bad coil pattern");

   // a request taken with no result waiting yields a result through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result missing after request");

   // pad bits stay clear
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_DATA_W-2] == 2'b00)
      else $error("rsp pad bits set");

endmodule

bind half_step_stepper_positioner hssp_checker u_hssp_checker (.*);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the half-step stepper positioner. A local model of
// position, phase, elapsed count and coil drive predicts every result; tick
// and load requests go in through the stream input with random bursts and
// gaps, results are taken with a random stall pattern and a long hold-off,
// and control values are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import hssp_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 4;
   localparam int RANDOM_ITEMS  = 1950;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd2;
   localparam logic [COIL_W-1:0] HALF_STEP_PATTERN [8] =
      '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // motor model state
   cfg_type               motor_cfg;
   logic [POS_W-1:0]      motor_pos;
   logic [PHASE_W-1:0]    motor_phase;
   logic [INTERVAL_W-1:0] motor_elapsed;
   logic [COIL_W-1:0]     motor_coils;
   result_type            motor_status_q[$];

   int  gap_max    = 0;
   int  stall_pct  = 0;
   int  burst_left = 0;
   int  n_requests = 0;
   int  n_loads    = 0;
   int  n_steps    = 0;
   int  n_arrivals = 0;
   int  n_results  = 0;
   int  n_errors   = 0;
   logic hold_active = 1'b0;
   event long_hold_ev;

   half_step_stepper_positioner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // target_position, new_position
      .req_tuser  (req_tuser),   // kind
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // coils, stepped, ready_res, position, pad
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic result_type advance_motor(input item_type it);
      result_type       r;
      logic [POS_W:0]   nxt;
      r.stepped   = 1'b0;
      r.ready_res = 1'b0;
      if (it.kind == KIND_LOAD) begin
         motor_pos = it.new_position;
      end else begin
         if (motor_elapsed != ELAPSED_MAX) begin
            motor_elapsed = motor_elapsed + 1'b1;
         end
         if (motor_pos != it.target_position && motor_elapsed >= motor_cfg.step_interval) begin
            r.stepped     = 1'b1;
            motor_elapsed = '0;
            motor_phase   = motor_phase + 1'b1;
            motor_coils   = HALF_STEP_PATTERN[motor_phase];
            nxt = {1'b0, motor_pos} + 1'b1;
            if (nxt > {1'b0, motor_cfg.wrap_limit} || nxt[POS_W]) begin
               nxt = '0;
            end
            motor_pos = nxt[POS_W-1:0];
            if (motor_pos == it.target_position) begin
               r.ready_res = 1'b1;
               motor_coils = '0;
            end
         end
      end
      r.coils    = motor_coils;
      r.position = motor_pos;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      n_errors++;
      if (n_errors <= 40) begin
         $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                  n_results, field, got, want);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.coils     = rsp_tdata[3:0];
         got.stepped   = rsp_tdata[4];
         got.ready_res = rsp_tdata[5];
         got.position  = rsp_tdata[21:6];
         if (motor_status_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 0);
         end else begin
            want = motor_status_q.pop_front();
            if (got.coils != want.coils)
               report_mismatch("coils", got.coils, want.coils);
            if (got.stepped != want.stepped)
               report_mismatch("stepped", got.stepped, want.stepped);
            if (got.ready_res != want.ready_res)
               report_mismatch("ready_res", got.ready_res, want.ready_res);
            if (got.position != want.position)
               report_mismatch("position", got.position, want.position);
            n_steps    += want.stepped;
            n_arrivals += want.ready_res;
         end
         n_results++;
      end
   end

   // result side stall pattern
   always @(posedge clock) begin
      if (hold_active) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      forever begin
         @(long_hold_ev);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active = 1'b0;
      end
   end

   task automatic send_request(input kind_type kind, input logic [POS_W-1:0] target,
                               input logic [POS_W-1:0] new_pos);
      item_type it;
      int       gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      it.kind            = kind;
      it.target_position = target;
      it.new_position    = new_pos;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {new_pos, target};
      do @(posedge clock); while (!req_tready);
      motor_status_q.push_back(advance_motor(it));
      n_requests++;
      if (kind == KIND_LOAD) n_loads++;
   endtask

   task automatic tick(input logic [POS_W-1:0] target);
      send_request(KIND_TICK, target, POS_W'($urandom));
   endtask

   task automatic load(input logic [POS_W-1:0] new_pos);
      send_request(KIND_LOAD, POS_W'($urandom), new_pos);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (motor_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_STEP_INTERVAL: motor_cfg.step_interval = value;
         CSR_WRAP_LIMIT:    motor_cfg.wrap_limit    = value[POS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic test_reset_state();
      // saturated elapsed count lets the first tick toward a new target step at once
      tick(16'd0);
      tick(16'd5);
      tick(16'd5);
      load(16'hFFFF);
      load(16'd0);
      drain();
   endtask

   task automatic test_extremes();
      csr_write(CSR_STEP_INTERVAL, 20'd0);
      csr_write(CSR_WRAP_LIMIT, 20'hFFFFF);
      load(16'd65534);
      tick(16'd0);
      tick(16'd0);
      tick(16'd0);
      // every phase of the pattern
      load(16'd0);
      repeat (9) tick(16'hFFFF);
      drain();
      // unreachable target keeps wrapping
      csr_write(CSR_STEP_INTERVAL, 20'd1);
      csr_write(CSR_WRAP_LIMIT, 20'd10);
      load(16'd9);
      repeat (3) tick(16'd20);
      drain();
      // wrap limit of zero lands every step on zero
      csr_write(CSR_WRAP_LIMIT, 20'd0);
      load(16'd3);
      tick(16'd0);
      tick(16'd5);
      drain();
      csr_write(CSR_STEP_INTERVAL, 20'hFFFFF);
      csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
      tick(16'd5);
      tick(16'd5);
      drain();
   endtask

   task automatic run_moves(input int items);
      int stop_at;
      int span;
      int r;
      int budget;
      logic [POS_W-1:0] target;
      stop_at = n_requests + items;
      span = int'(motor_cfg.wrap_limit) + 1;
      while (n_requests < stop_at) begin
         r = $urandom_range(99);
         if (r < 70) begin
            // well-formed move to a nearby reachable target
            if ($urandom_range(3) == 0) load(POS_W'($urandom_range(0, span - 1)));
            target = POS_W'((int'(motor_pos) + $urandom_range(1, 20)) % span);
            budget = 150;
            while (motor_pos != target && budget != 0 && n_requests < stop_at) begin
               tick(target);
               budget--;
            end
         end else if (r < 85) begin
            load(POS_W'($urandom));
         end else begin
            tick(POS_W'($urandom));
         end
      end
   endtask

   task automatic test_random_moves();
      int per_phase;
      per_phase = RANDOM_ITEMS / 5;
      csr_write(CSR_STEP_INTERVAL, 20'd0);
      csr_write(CSR_WRAP_LIMIT, 20'd40);
      gap_max = 0; stall_pct = 0;
      run_moves(per_phase);
      drain();
      csr_write(CSR_STEP_INTERVAL, 20'd1);
      csr_write(CSR_WRAP_LIMIT, 20'd200);
      gap_max = 3; stall_pct = 30;
      run_moves(per_phase);
      drain();
      csr_write(CSR_STEP_INTERVAL, CSR_DATA_W'($urandom_range(2, 6)));
      csr_write(CSR_WRAP_LIMIT, CSR_DATA_W'(WRAP_LIMIT_RESET));
      gap_max = 6; stall_pct = 50;
      run_moves(per_phase);
      drain();
      csr_write(CSR_STEP_INTERVAL, 20'd2);
      csr_write(CSR_WRAP_LIMIT, 20'd65535);
      gap_max = 2; stall_pct = 10;
      run_moves(per_phase);
      drain();
      csr_write(CSR_STEP_INTERVAL, CSR_DATA_W'($urandom_range(0, 8)));
      csr_write(CSR_WRAP_LIMIT, CSR_DATA_W'($urandom_range(1, 500)));
      gap_max = 4; stall_pct = 40;
      run_moves(per_phase);
      drain();
   endtask

   task automatic test_backpressure();
      gap_max = 0; stall_pct = 0;
      -> long_hold_ev;
      run_moves(60);
      drain();
   endtask

   initial begin
      motor_cfg.step_interval = STEP_INTERVAL_RESET;
      motor_cfg.wrap_limit    = WRAP_LIMIT_RESET;
      motor_pos     = '0;
      motor_phase   = '0;
      motor_elapsed = ELAPSED_MAX;
      motor_coils   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_extremes();
      test_random_moves();
      test_backpressure();
      drain();
      $display("covered %0d requests (%0d loads), %0d half steps, %0d arrivals",
               n_requests, n_loads, n_steps, n_arrivals);
      $display("control settings swept from zero to full range, with stalls and hold-off");
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: half_step_stepper_positioner.f
rtl/core/hssp_pkg.sv
rtl/core/hssp_ingress.sv
rtl/core/hssp_motion.sv
rtl/core/hssp_egress.sv
rtl/core/half_step_stepper_positioner.sv
rtl/core/hssp_checker.sv
verif/tb_top.sv
